// ===== hdl/mgq_pkg.sv =====
package mgq_pkg;

  localparam int MAX_GROUPS  = 8;
  localparam int MAX_MEMBERS = 8;
  localparam int QUEUE_DEPTH = 16;

  // Index and count widths
  localparam int GI_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int MI_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int QI_W = $clog2(QUEUE_DEPTH);
  localparam int MC_W = $clog2(MAX_MEMBERS + 1);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int RC_W = MC_W;

  localparam int GID_W = 16;
  localparam int EP_W  = 32;
  localparam int MSG_W = 64;

  // Member store: endpoint and read cursor, addressed {group slot, member index}
  localparam int MA_W  = GI_W + MI_W;
  localparam int MEM_W = EP_W + QC_W;
  // Ring store: payload and read count, addressed {group slot, ring index}
  localparam int RA_W  = GI_W + QI_W;
  localparam int RNG_W = MSG_W + RC_W;

  // Request kinds
  localparam logic [2:0] K_OPEN    = 3'd0;
  localparam logic [2:0] K_CLOSE   = 3'd1;
  localparam logic [2:0] K_SEND    = 3'd2;
  localparam logic [2:0] K_RECV    = 3'd3;
  localparam logic [2:0] K_RECOVER = 3'd4;
  localparam logic [2:0] K_INFO    = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_NOTMEM = 3'd2;
  localparam logic [2:0] ST_NOGRP  = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;
  localparam logic [2:0] ST_TABLE  = 3'd5;

endpackage

// ===== hdl/multicast_group_queue_unit.sv =====
// Multicast group queue. A request (kind, group, member, message word) is taken
// when start is high and busy is low; busy then stays high until the last
// result has been issued. Every result appears for exactly one cycle with
// result_valid_o high and cannot be stalled; last_o marks the final result of a
// request. Info on an existing group gives one result per member, everything
// else gives one. A request walks the group table one slot a cycle, stopping
// at a match. It then passes a dispatch state and makes at most two passes
// over the members (search, compaction or listing first; shift or cursor
// decrement second), plus ring access. The final result comes in the same
// cycle in which busy falls. All work goes through one member RAM and one
// ring RAM, each with one write port and one read port.
module multicast_group_queue_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind_i,
  input  logic [15:0]               group_id_i,
  input  logic signed [31:0]        member_id_i,
  input  logic [63:0]               message_word_i,
  output logic                      result_valid_o,
  output logic [2:0]                status_o,
  output logic [63:0]               message_out_o,
  output logic [3:0]                member_count_o,
  output logic signed [31:0]        member_endpoint_o,
  output logic                      last_o
);

  localparam int GI_W  = mgq_pkg::GI_W;
  localparam int MI_W  = mgq_pkg::MI_W;
  localparam int QI_W  = mgq_pkg::QI_W;
  localparam int MC_W  = mgq_pkg::MC_W;
  localparam int QC_W  = mgq_pkg::QC_W;
  localparam int RC_W  = mgq_pkg::RC_W;
  localparam int EP_W  = mgq_pkg::EP_W;
  localparam int MSG_W = mgq_pkg::MSG_W;
  localparam int NG    = mgq_pkg::MAX_GROUPS;

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GSRCH = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_MRD   = 5'd3;
  localparam logic [4:0] S_MCMP  = 5'd4;
  localparam logic [4:0] S_MDONE = 5'd5;
  localparam logic [4:0] S_SHRD  = 5'd6;
  localparam logic [4:0] S_SHWR  = 5'd7;
  localparam logic [4:0] S_RXRD  = 5'd8;
  localparam logic [4:0] S_RXUPD = 5'd9;
  localparam logic [4:0] S_CPRD  = 5'd10;
  localparam logic [4:0] S_CPCMP = 5'd11;
  localparam logic [4:0] S_CHRD  = 5'd12;
  localparam logic [4:0] S_CHCMP = 5'd13;
  localparam logic [4:0] S_DCRD  = 5'd14;
  localparam logic [4:0] S_DCWR  = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_INRD  = 5'd17;
  localparam logic [4:0] S_INOUT = 5'd18;

  logic [4:0] state_q;

  // Latched request
  logic [2:0]       kind_q;
  logic [15:0]      gid_q;
  logic [EP_W-1:0]  who_q;
  logic [MSG_W-1:0] word_q;

  // Group table
  logic             gvalid_q [NG];
  logic [15:0]      gid_tab_q [NG];
  logic [MC_W-1:0]  nmem_q [NG];
  logic [QI_W-1:0]  head_q [NG];
  logic [QC_W-1:0]  size_q [NG];

  // Search and loop control
  logic [GI_W-1:0]  gs_q;
  logic [GI_W-1:0]  slot_q;
  logic             found_q;
  logic             free_found_q;
  logic [GI_W-1:0]  free_slot_q;
  logic [MC_W-1:0]  cnt_q;
  logic [MC_W-1:0]  wptr_q;
  logic             mfound_q;
  logic [MC_W-1:0]  midx_q;
  logic [QC_W-1:0]  mcur_q;
  logic [QI_W-1:0]  rx_idx_q;
  logic [2:0]       st_q;
  logic [MSG_W-1:0] msg_q;

  // Result registers
  logic             res_valid_q;
  logic [2:0]       res_status_q;
  logic [MSG_W-1:0] res_msg_q;
  logic [3:0]       res_cnt_q;
  logic [EP_W-1:0]  res_ep_q;
  logic             res_last_q;

  // RAM ports
  logic                    m_we;
  logic [mgq_pkg::MA_W-1:0]  m_waddr, m_raddr;
  logic [mgq_pkg::MEM_W-1:0] m_wdata, m_rdata;
  logic                    r_we;
  logic [mgq_pkg::RA_W-1:0]  r_waddr, r_raddr;
  logic [mgq_pkg::RNG_W-1:0] r_wdata, r_rdata;

  // Current group view
  logic [MC_W-1:0] nmem_c;
  logic [QI_W-1:0] head_c;
  logic [QC_W-1:0] size_c;
  logic [MC_W-1:0] cnt_inc;
  logic [EP_W-1:0] rd_ep;
  logic [QC_W-1:0] rd_cur;
  logic [MSG_W-1:0] rd_pay;
  logic [RC_W-1:0] rd_rc;
  logic            new_group;

  // Add an offset below the depth to a ring index, wrapping once
  function automatic logic [QI_W-1:0] ring_idx(input logic [QI_W-1:0] base,
                                               input logic [QC_W-1:0] off);
    logic [QC_W:0] s;
    s = (QC_W+1)'(base) + (QC_W+1)'(off);
    if (s >= (QC_W+1)'(mgq_pkg::QUEUE_DEPTH)) begin
      s = s - (QC_W+1)'(mgq_pkg::QUEUE_DEPTH);
    end
    return s[QI_W-1:0];
  endfunction

  assign nmem_c  = nmem_q[slot_q];
  assign head_c  = head_q[slot_q];
  assign size_c  = size_q[slot_q];
  assign cnt_inc = cnt_q + MC_W'(1);
  assign rd_ep   = m_rdata[mgq_pkg::MEM_W-1:QC_W];
  assign rd_cur  = m_rdata[QC_W-1:0];
  assign rd_pay  = r_rdata[mgq_pkg::RNG_W-1:RC_W];
  assign rd_rc   = r_rdata[RC_W-1:0];

  assign new_group = (state_q == S_DISP) && (kind_q == mgq_pkg::K_OPEN) && !found_q &&
                     free_found_q;

  // Member RAM port steering
  always_comb begin
    m_we    = 1'b0;
    m_waddr = {slot_q, cnt_q[MI_W-1:0]};
    m_wdata = {who_q, QC_W'(0)};
    m_raddr = {slot_q, cnt_q[MI_W-1:0]};
    unique case (state_q)
      S_DISP: begin
        m_we    = new_group;
        m_waddr = {free_slot_q, MI_W'(0)};
      end
      S_MDONE: begin
        m_we    = (kind_q == mgq_pkg::K_OPEN) && !mfound_q &&
                  (nmem_c < MC_W'(mgq_pkg::MAX_MEMBERS));
        m_waddr = {slot_q, nmem_c[MI_W-1:0]};
      end
      S_SHRD: begin
        m_raddr = {slot_q, cnt_inc[MI_W-1:0]};
      end
      S_SHWR: begin
        m_we    = 1'b1;
        m_wdata = m_rdata;
      end
      S_RXUPD: begin
        m_we    = 1'b1;
        m_waddr = {slot_q, midx_q[MI_W-1:0]};
        m_wdata = {who_q, mcur_q + QC_W'(1)};
      end
      S_CPCMP: begin
        m_we    = (rd_cur != '0);
        m_waddr = {slot_q, wptr_q[MI_W-1:0]};
        m_wdata = m_rdata;
      end
      S_DCWR: begin
        m_we    = (rd_cur != '0);
        m_wdata = {rd_ep, rd_cur - QC_W'(1)};
      end
      default: begin
      end
    endcase
  end

  // Ring RAM port steering
  always_comb begin
    r_we    = 1'b0;
    r_waddr = {slot_q, rx_idx_q};
    r_wdata = {word_q, RC_W'(0)};
    r_raddr = {slot_q, head_c};
    unique case (state_q)
      S_DISP: begin
        r_we    = found_q && (kind_q == mgq_pkg::K_SEND) &&
                  (size_c < QC_W'(mgq_pkg::QUEUE_DEPTH));
        r_waddr = {slot_q, ring_idx(head_c, size_c)};
      end
      S_RXRD: begin
        r_raddr = {slot_q, rx_idx_q};
      end
      S_RXUPD: begin
        r_we    = 1'b1;
        r_wdata = {rd_pay, (rd_rc < RC_W'(mgq_pkg::MAX_MEMBERS)) ? rd_rc + RC_W'(1) : rd_rc};
      end
      default: begin
      end
    endcase
  end

  mgq_ram #(
    .WIDTH (mgq_pkg::MEM_W),
    .DEPTH (2 ** mgq_pkg::MA_W)
  ) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  mgq_ram #(
    .WIDTH (mgq_pkg::RNG_W),
    .DEPTH (2 ** mgq_pkg::RA_W)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  // Group identifiers need no reset: a slot is only compared once valid
  always_ff @(posedge clk_i) begin
    if (new_group) begin
      gid_tab_q[free_slot_q] <= gid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= '0;
      gid_q        <= '0;
      who_q        <= '0;
      word_q       <= '0;
      gs_q         <= '0;
      slot_q       <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      free_slot_q  <= '0;
      cnt_q        <= '0;
      wptr_q       <= '0;
      mfound_q     <= 1'b0;
      midx_q       <= '0;
      mcur_q       <= '0;
      rx_idx_q     <= '0;
      st_q         <= mgq_pkg::ST_OK;
      msg_q        <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= mgq_pkg::ST_OK;
      res_msg_q    <= '0;
      res_cnt_q    <= '0;
      res_ep_q     <= '0;
      res_last_q   <= 1'b0;
      for (int g = 0; g < NG; g++) begin
        gvalid_q[g] <= 1'b0;
        nmem_q[g]   <= '0;
        head_q[g]   <= '0;
        size_q[g]   <= '0;
      end
    end else begin
      // Results last one cycle; fields default to the plain single-result form
      res_valid_q  <= 1'b0;
      res_status_q <= mgq_pkg::ST_OK;
      res_msg_q    <= '0;
      res_cnt_q    <= '0;
      res_ep_q     <= '0;
      res_last_q   <= 1'b1;

      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q       <= kind_i;
            gid_q        <= group_id_i;
            who_q        <= member_id_i;
            word_q       <= message_word_i;
            gs_q         <= '0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= S_GSRCH;
          end
        end

        // Walk the group table one slot a cycle; note the first free slot
        S_GSRCH: begin
          if (gvalid_q[gs_q] && (gid_tab_q[gs_q] == gid_q)) begin
            found_q <= 1'b1;
            slot_q  <= gs_q;
            state_q <= S_DISP;
          end else begin
            if (!gvalid_q[gs_q] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_slot_q  <= gs_q;
            end
            if (gs_q == GI_W'(NG - 1)) begin
              state_q <= S_DISP;
            end else begin
              gs_q <= gs_q + GI_W'(1);
            end
          end
        end

        S_DISP: begin
          cnt_q    <= '0;
          wptr_q   <= '0;
          mfound_q <= 1'b0;
          st_q     <= mgq_pkg::ST_OK;
          msg_q    <= '0;
          if (kind_q > mgq_pkg::K_INFO) begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (!found_q) begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (kind_q != mgq_pkg::K_OPEN) begin
              res_status_q <= mgq_pkg::ST_NOGRP;
            end else if (free_found_q) begin
              gvalid_q[free_slot_q] <= 1'b1;
              nmem_q[free_slot_q]   <= MC_W'(1);
              head_q[free_slot_q]   <= '0;
              size_q[free_slot_q]   <= '0;
            end else begin
              res_status_q <= mgq_pkg::ST_TABLE;
            end
          end else begin
            case (kind_q)
              mgq_pkg::K_SEND: begin
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
                if (size_c < QC_W'(mgq_pkg::QUEUE_DEPTH)) begin
                  size_q[slot_q] <= size_c + QC_W'(1);
                end else begin
                  res_status_q <= mgq_pkg::ST_FULL;
                end
              end
              mgq_pkg::K_RECOVER: begin
                state_q <= S_CPRD;
              end
              mgq_pkg::K_INFO: begin
                if (nmem_c == '0) begin
                  res_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                end else begin
                  state_q <= S_INRD;
                end
              end
              default: begin
                state_q <= S_MRD;
              end
            endcase
          end
        end

        // Member search: read, then compare
        S_MRD: begin
          if (cnt_q >= nmem_c) begin
            state_q <= S_MDONE;
          end else begin
            state_q <= S_MCMP;
          end
        end

        S_MCMP: begin
          if (rd_ep == who_q) begin
            mfound_q <= 1'b1;
            midx_q   <= cnt_q;
            mcur_q   <= rd_cur;
            state_q  <= S_MDONE;
          end else begin
            cnt_q   <= cnt_inc;
            state_q <= S_MRD;
          end
        end

        S_MDONE: begin
          case (kind_q)
            mgq_pkg::K_OPEN: begin
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
              if (!mfound_q) begin
                if (nmem_c < MC_W'(mgq_pkg::MAX_MEMBERS)) begin
                  nmem_q[slot_q] <= nmem_c + MC_W'(1);
                end else begin
                  res_status_q <= mgq_pkg::ST_TABLE;
                end
              end
            end
            mgq_pkg::K_CLOSE: begin
              if (mfound_q) begin
                cnt_q   <= midx_q;
                state_q <= S_SHRD;
              end else begin
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end
            end
            default: begin
              if (!mfound_q) begin
                res_valid_q  <= 1'b1;
                res_status_q <= mgq_pkg::ST_NOTMEM;
                state_q      <= S_IDLE;
              end else if (mcur_q < size_c) begin
                rx_idx_q <= ring_idx(head_c, mcur_q);
                state_q  <= S_RXRD;
              end else begin
                st_q    <= mgq_pkg::ST_EMPTY;
                state_q <= S_CHRD;
              end
            end
          endcase
        end

        // Close: shift the later members down by one
        S_SHRD: begin
          if (cnt_inc >= nmem_c) begin
            nmem_q[slot_q] <= nmem_c - MC_W'(1);
            if (nmem_c == MC_W'(1)) begin
              gvalid_q[slot_q] <= 1'b0;
            end
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_SHWR;
          end
        end

        S_SHWR: begin
          cnt_q   <= cnt_inc;
          state_q <= S_SHRD;
        end

        // Receive: fetch the entry, bump its read count and the cursor
        S_RXRD: begin
          state_q <= S_RXUPD;
        end

        S_RXUPD: begin
          msg_q   <= rd_pay;
          state_q <= S_CHRD;
        end

        // Recover: compact the member list, keeping members that have read
        S_CPRD: begin
          if (cnt_q >= nmem_c) begin
            nmem_q[slot_q] <= wptr_q;
            state_q        <= S_CHRD;
          end else begin
            state_q <= S_CPCMP;
          end
        end

        S_CPCMP: begin
          if (rd_cur != '0) begin
            wptr_q <= wptr_q + MC_W'(1);
          end
          cnt_q   <= cnt_inc;
          state_q <= S_CPRD;
        end

        // Oldest-entry check
        S_CHRD: begin
          if (size_c == '0) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_CHCMP;
          end
        end

        S_CHCMP: begin
          if (rd_rc >= nmem_c) begin
            head_q[slot_q] <= ring_idx(head_c, QC_W'(1));
            size_q[slot_q] <= size_c - QC_W'(1);
            cnt_q          <= '0;
            state_q        <= S_DCRD;
          end else begin
            state_q <= S_FIN;
          end
        end

        // Drop every nonzero cursor by one after the oldest entry leaves
        S_DCRD: begin
          if (cnt_q >= nmem_c) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_DCWR;
          end
        end

        S_DCWR: begin
          cnt_q   <= cnt_inc;
          state_q <= S_DCRD;
        end

        S_FIN: begin
          if (nmem_c == '0) begin
            gvalid_q[slot_q] <= 1'b0;
          end
          res_valid_q  <= 1'b1;
          res_status_q <= st_q;
          res_msg_q    <= msg_q;
          state_q      <= S_IDLE;
        end

        // Info: one result per member
        S_INRD: begin
          state_q <= S_INOUT;
        end

        S_INOUT: begin
          res_valid_q <= 1'b1;
          res_cnt_q   <= 4'(nmem_c);
          res_ep_q    <= rd_ep;
          res_last_q  <= (cnt_inc == nmem_c);
          cnt_q       <= cnt_inc;
          if (cnt_inc == nmem_c) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_INRD;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = res_valid_q;
  assign status_o          = res_status_q;
  assign message_out_o     = res_msg_q;
  assign member_count_o    = res_cnt_q;
  assign member_endpoint_o = res_ep_q;
  assign last_o            = res_last_q;

`ifndef NO_ASSERTIONS
  // A result only follows a cycle of work
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result issued without a request in progress");

  // An accepted request always makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // The addressed ring never holds more than its depth
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && found_q) |-> (size_c <= QC_W'(mgq_pkg::QUEUE_DEPTH)))
    else $error("ring size beyond depth");

  // A result that is not final comes while the block is still busy
  a_more_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("intermediate result with sequencer idle");
`endif

endmodule

// ===== hdl/mgq_ram.sv =====
module mgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== dv/multicast_group_queue_unit_tb.sv =====
module multicast_group_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Reply fields as driven by the block; the listed member rides in endpoint.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] message;
    logic [3:0]  count;
    logic [31:0] endpoint;
    logic        last;
  } reply_t;

  typedef struct {
    logic [15:0] gid;
    int unsigned nmem;
    logic [31:0] ep [mgq_pkg::MAX_MEMBERS];
    int unsigned cur [mgq_pkg::MAX_MEMBERS];
    logic [63:0] pay [mgq_pkg::QUEUE_DEPTH];
    int unsigned rc [mgq_pkg::QUEUE_DEPTH];
    int unsigned head;
    int unsigned size;
  } group_t;

  // Directed row: request plus an optional hand-typed reply status.
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] gid;
    logic [31:0] mid;
    logic [63:0] word;
    bit          typed;
    logic [2:0]  status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind_i = '0;
  logic [15:0] group_id_i = '0;
  logic signed [31:0] member_id_i = '0;
  logic [63:0] message_word_i = '0;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [63:0] message_out_o;
  logic [3:0]  member_count_o;
  logic signed [31:0] member_endpoint_o;
  logic        last_o;

  multicast_group_queue_unit uut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .group_id_i, .member_id_i,
    .message_word_i, .result_valid_o, .status_o, .message_out_o,
    .member_count_o, .member_endpoint_o, .last_o
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  group_t      groups [mgq_pkg::MAX_GROUPS];
  int unsigned group_total;
  reply_t      pending_replies [$];
  int          error_count;
  longint      cycle_count;
  int unsigned send_idle_pct;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int find_group(input logic [15:0] gid);
    for (int i = 0; i < group_total; i++)
      if (groups[i].gid == gid) return i;
    return -1;
  endfunction

  function automatic int find_member(input int gi, input logic [31:0] ep);
    for (int i = 0; i < groups[gi].nmem; i++)
      if (groups[gi].ep[i] == ep) return i;
    return -1;
  endfunction

  function automatic void drop_member(input int gi, input int mi);
    for (int j = mi; j + 1 < groups[gi].nmem; j++) begin
      groups[gi].ep[j] = groups[gi].ep[j + 1];
      groups[gi].cur[j] = groups[gi].cur[j + 1];
    end
    groups[gi].nmem--;
  endfunction

  function automatic void drop_group(input int gi);
    for (int j = gi; j + 1 < group_total; j++) groups[j] = groups[j + 1];
    group_total--;
  endfunction

  // Retire the oldest ring entry once every member has read it.
  function automatic void retire_oldest(input int gi);
    if (groups[gi].size > 0 && groups[gi].rc[groups[gi].head] >= groups[gi].nmem) begin
      groups[gi].head = (groups[gi].head + 1) % mgq_pkg::QUEUE_DEPTH;
      groups[gi].size--;
      for (int i = 0; i < groups[gi].nmem; i++)
        if (groups[gi].cur[i] > 0) groups[gi].cur[i]--;
    end
  endfunction

  function automatic reply_t mk(input logic [2:0] st, input logic [63:0] msg = '0);
    reply_t r;
    r = '0;
    r.status = st;
    r.message = msg;
    r.last = 1'b1;
    return r;
  endfunction

  // Advance the shadow table by one request and queue the replies it yields.
  function automatic void predict_replies(input logic [2:0] kind, input logic [15:0] gid,
                                          input logic [31:0] who, input logic [63:0] word);
    int gi;
    int mi;
    int unsigned idx;
    reply_t r;
    gi = find_group(gid);
    if (kind > mgq_pkg::K_INFO) begin
      pending_replies.push_back(mk(mgq_pkg::ST_OK));
      return;
    end
    if (gi < 0 && kind != mgq_pkg::K_OPEN) begin
      pending_replies.push_back(mk(mgq_pkg::ST_NOGRP));
      return;
    end
    case (kind)
      mgq_pkg::K_OPEN: begin
        if (gi < 0) begin
          if (group_total >= mgq_pkg::MAX_GROUPS) begin
            pending_replies.push_back(mk(mgq_pkg::ST_TABLE));
            return;
          end
          gi = group_total;
          groups[gi].gid = gid;
          groups[gi].nmem = 1;
          groups[gi].ep[0] = who;
          groups[gi].cur[0] = 0;
          groups[gi].head = 0;
          groups[gi].size = 0;
          group_total++;
        end else if (find_member(gi, who) < 0) begin
          if (groups[gi].nmem >= mgq_pkg::MAX_MEMBERS) begin
            pending_replies.push_back(mk(mgq_pkg::ST_TABLE));
            return;
          end
          groups[gi].ep[groups[gi].nmem] = who;
          groups[gi].cur[groups[gi].nmem] = 0;
          groups[gi].nmem++;
        end
        pending_replies.push_back(mk(mgq_pkg::ST_OK));
      end
      mgq_pkg::K_CLOSE: begin
        mi = find_member(gi, who);
        if (mi >= 0) begin
          drop_member(gi, mi);
          if (groups[gi].nmem == 0) drop_group(gi);
        end
        pending_replies.push_back(mk(mgq_pkg::ST_OK));
      end
      mgq_pkg::K_SEND: begin
        if (groups[gi].size >= mgq_pkg::QUEUE_DEPTH) begin
          pending_replies.push_back(mk(mgq_pkg::ST_FULL));
          return;
        end
        idx = (groups[gi].head + groups[gi].size) % mgq_pkg::QUEUE_DEPTH;
        groups[gi].pay[idx] = word;
        groups[gi].rc[idx] = 0;
        groups[gi].size++;
        pending_replies.push_back(mk(mgq_pkg::ST_OK));
      end
      mgq_pkg::K_RECV: begin
        mi = find_member(gi, who);
        if (mi < 0) begin
          pending_replies.push_back(mk(mgq_pkg::ST_NOTMEM));
          return;
        end
        r = mk(mgq_pkg::ST_EMPTY);
        if (groups[gi].cur[mi] < groups[gi].size) begin
          idx = (groups[gi].head + groups[gi].cur[mi]) % mgq_pkg::QUEUE_DEPTH;
          r = mk(mgq_pkg::ST_OK, groups[gi].pay[idx]);
          if (groups[gi].rc[idx] < mgq_pkg::MAX_MEMBERS) groups[gi].rc[idx]++;
          groups[gi].cur[mi]++;
        end
        retire_oldest(gi);
        pending_replies.push_back(r);
      end
      mgq_pkg::K_RECOVER: begin
        mi = 0;
        while (mi < groups[gi].nmem) begin
          if (groups[gi].cur[mi] == 0) drop_member(gi, mi);
          else mi++;
        end
        retire_oldest(gi);
        if (groups[gi].nmem == 0) drop_group(gi);
        pending_replies.push_back(mk(mgq_pkg::ST_OK));
      end
      default: begin
        for (int i = 0; i < groups[gi].nmem; i++) begin
          r = mk(mgq_pkg::ST_OK);
          r.count = 4'(groups[gi].nmem);
          r.endpoint = groups[gi].ep[i];
          r.last = (i + 1 == groups[gi].nmem);
          pending_replies.push_back(r);
        end
      end
    endcase
  endfunction

  // Check each strobed reply against the oldest expectation.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply status", 64'(status_o), 64'h0);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) report_mismatch("status", 64'(status_o), 64'(want.status));
        if (message_out_o !== want.message) report_mismatch("message", message_out_o, want.message);
        if (member_count_o !== want.count)
          report_mismatch("member count", 64'(member_count_o), 64'(want.count));
        if (member_endpoint_o !== want.endpoint)
          report_mismatch("endpoint", 64'(member_endpoint_o), 64'(want.endpoint));
        if (last_o !== want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
      end
    end
  end

  // Watchdog: end the run and report errors if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("multicast_group_queue_unit_tb: done, errors");
      $finish;
    end
  end

  // Drive one request at the falling edge and hold it until it is taken. busy only
  // moves at the rising edge, so its value at the falling edge decides the next one.
  task automatic issue_request(input logic [2:0] kind, input logic [15:0] gid,
                               input logic [31:0] mid, input logic [63:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    kind_i <= kind;
    group_id_i <= gid;
    member_id_i <= mid;
    message_word_i <= word;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_replies(kind, gid, mid, word);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_replies.size() != 0 || busy) @(negedge clk_i);
  endtask

  // Random request; most target a small pool of groups and members so that
  // sequences of open, send and receive actually reach the rings.
  task automatic random_request();
    logic [2:0]  kind;
    logic [15:0] gid;
    logic [31:0] mid;
    logic [63:0] word;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) kind = mgq_pkg::K_OPEN;
    else if (pick < 28) kind = mgq_pkg::K_CLOSE;
    else if (pick < 50) kind = mgq_pkg::K_SEND;
    else if (pick < 78) kind = mgq_pkg::K_RECV;
    else if (pick < 84) kind = mgq_pkg::K_RECOVER;
    else if (pick < 95) kind = mgq_pkg::K_INFO;
    else kind = 3'($urandom_range(7));
    gid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(9));
    mid = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(10)) - 32'd3;
    word = {32'($urandom), 32'($urandom)};
    issue_request(kind, gid, mid, word);
  endtask

  row_t directed [23] = '{
    '{mgq_pkg::K_INFO,    16'h0000, 32'h0,        64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_RECV,    16'hFFFF, 32'h0,        64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_CLOSE,   16'h0001, 32'h1,        64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_RECOVER, 16'h0001, 32'h1,        64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_SEND,    16'h0001, 32'h1,        64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{3'd6,               16'h0001, 32'h1,        64'h0, 1'b1, mgq_pkg::ST_OK},
    '{3'd7,               16'hFFFF, 32'hFFFFFFFF, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_OPEN,    16'hFFFF, 32'h80000000, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_OPEN,    16'hFFFF, 32'h7FFFFFFF, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_OPEN,    16'hFFFF, 32'h80000000, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_RECV,    16'hFFFF, 32'h7FFFFFFF, 64'h0, 1'b1, mgq_pkg::ST_EMPTY},
    '{mgq_pkg::K_RECV,    16'hFFFF, 32'h00000005, 64'h0, 1'b1, mgq_pkg::ST_NOTMEM},
    '{mgq_pkg::K_SEND,    16'hFFFF, 32'h00000009, 64'hFFFFFFFFFFFFFFFF, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_SEND,    16'hFFFF, 32'h80000000, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_RECV,    16'hFFFF, 32'h7FFFFFFF, 64'h0, 1'b0, mgq_pkg::ST_OK},
    '{mgq_pkg::K_RECV,    16'hFFFF, 32'h80000000, 64'h0, 1'b0, mgq_pkg::ST_OK},
    '{mgq_pkg::K_INFO,    16'hFFFF, 32'h0,        64'h0, 1'b0, mgq_pkg::ST_OK},
    '{mgq_pkg::K_OPEN,    16'hFFFF, 32'h00000003, 64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_RECOVER, 16'hFFFF, 32'h0,        64'h0, 1'b1, mgq_pkg::ST_OK},
    '{mgq_pkg::K_CLOSE,   16'hFFFF, 32'h00000042, 64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_CLOSE,   16'hFFFF, 32'h7FFFFFFF, 64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_CLOSE,   16'hFFFF, 32'h80000000, 64'h0, 1'b1, mgq_pkg::ST_NOGRP},
    '{mgq_pkg::K_INFO,    16'hFFFF, 32'h0,        64'h0, 1'b1, mgq_pkg::ST_NOGRP}
  };

  initial begin
    reply_t typed_reply;
    send_idle_pct = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: for typed rows the predicted reply status is checked against the hand value.
    foreach (directed[i]) begin
      issue_request(directed[i].kind, directed[i].gid, directed[i].mid, directed[i].word);
      if (directed[i].typed && pending_replies.size() != 0) begin
        typed_reply = pending_replies[pending_replies.size() - 1];
        if (typed_reply.status !== directed[i].status)
          report_mismatch("table row status", 64'(typed_reply.status), 64'(directed[i].status));
      end
    end
    wait_drained();

    // Fill the table, then overflow it; fill one group and its ring.
    for (int g = 0; g < mgq_pkg::MAX_GROUPS + 1; g++)
      issue_request(mgq_pkg::K_OPEN, 16'(100 + g), 32'd1, '0);
    for (int m = 2; m < mgq_pkg::MAX_MEMBERS + 3; m++)
      issue_request(mgq_pkg::K_OPEN, 16'd100, 32'(m), '0);
    for (int s = 0; s < mgq_pkg::QUEUE_DEPTH + 2; s++)
      issue_request(mgq_pkg::K_SEND, 16'd100, 32'd0, {32'($urandom), 32'($urandom)});
    issue_request(mgq_pkg::K_INFO, 16'd100, 32'd0, '0);
    for (int g = 0; g < mgq_pkg::MAX_GROUPS; g++)
      issue_request(mgq_pkg::K_RECOVER, 16'(100 + g), 32'd0, '0);

    // Hold off until every expected reply has come back.
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 59 : 0;
      repeat (55) random_request();
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("multicast_group_queue_unit_tb: done, clean");
    end else begin
      $display("multicast_group_queue_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mgq_pkg.sv
hdl/mgq_ram.sv
hdl/multicast_group_queue_unit.sv
dv/multicast_group_queue_unit_tb.sv
